// File: rtl/ledc_pkg.sv
// Shared types, codes and helper functions of the LED drive controller.
`default_nettype none

package ledc_pkg;

  localparam int TIME_BITS = 32;
  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int PW = TIME_BITS + 8;
  localparam int CFG_IDX_BITS = 8;
  localparam int DIV_STEPS = 8;

  localparam logic [TIME_BITS-1:0] TMASK = {TIME_BITS{1'b1}};
  localparam logic [17:0] PCT_RECIP = 18'd167773;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLED     = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PWM_CAPABLE = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_CHANGE  = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RUN     = 8'd3;

  localparam logic [31:0] MIN_CHANGE_RST = 32'd1000;
  localparam logic [31:0] MAX_RUN_RST    = 32'd43200000;
  localparam logic [7:0]  BRIGHT_RST     = 8'd255;

  typedef enum logic [3:0] {
    REQ_TICK   = 4'd0,
    REQ_ON     = 4'd1,
    REQ_OFF    = 4'd2,
    REQ_TOGGLE = 4'd3,
    REQ_BRIGHT = 4'd4,
    REQ_PCT    = 4'd5,
    REQ_FADEIN = 4'd6,
    REQ_FADEOUT= 4'd7,
    REQ_STATS  = 4'd8
  } req_type_e;

  typedef enum logic [1:0] {
    RAMP_NONE = 2'd0,
    RAMP_IN   = 2'd1,
    RAMP_OUT  = 2'd2
  } ramp_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } ledc_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_STEP
  } ledc_div_state_e;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [7:0]  level_value;
    logic [31:0] ramp_ms;
  } led_req_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  drive_level;
    logic        lamp_on;
    logic        ramping;
    logic [31:0] activations;
    logic [31:0] run_total_ms;
    logic        over_limit;
  } led_rsp_t;

  typedef struct packed {
    logic                 ok;
    logic                 is_lit;
    logic                 run_active;
    ramp_mode_e           ramp_mode;
    logic [7:0]           bright;
    logic                 pwm;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] ramp_start;
    logic [TIME_BITS-1:0] ramp_len;
    logic [TIME_BITS-1:0] run_start;
    logic [31:0]          run_sum;
    logic [31:0]          act;
    logic [31:0]          max_run;
  } ledc_view_t;

  // Scale a percent to 0..255 as value*255/100, saturating.
  function automatic logic [7:0] pct_to_level(input logic [7:0] pct);
    logic [15:0] scaled;
    logic [33:0] prod;
    logic [9:0]  quo;
    scaled = 16'(pct) * 16'd255;
    prod   = 34'(scaled) * 34'(PCT_RECIP);
    quo    = prod[33:24];
    return (quo > 10'd255) ? 8'hFF : quo[7:0];
  endfunction

  // Clamp a fade length to the largest clock value.
  function automatic logic [TIME_BITS-1:0] sat_len(input logic [31:0] len);
    logic [63:0] wide;
    wide = 64'(len);
    if (wide > 64'(TMASK)) wide = 64'(TMASK);
    return TIME_BITS'(wide);
  endfunction

endpackage

`default_nettype wire

// File: rtl/ledc_div.sv
// Shared ramp unit: one multiply, then a bit-serial restoring divide.
`default_nettype none

module ledc_div
  import ledc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [TIME_BITS-1:0] elapsed_i,
  input  wire logic [7:0]           bright_i,
  input  wire logic [TIME_BITS-1:0] len_i,
  output logic                      done_o,
  output logic [7:0]                quot_o
);

  ledc_div_state_e      state_q, state_d;
  logic [TIME_BITS-1:0] e_q, e_d, len_q, len_d, rem_q, rem_d;
  logic [7:0]           b_q, b_d, low_q, low_d, quot_q, quot_d;
  logic [2:0]           cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [PW-1:0]        prod;
  logic [TIME_BITS:0]   trial;
  logic                 ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    b_q    <= b_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  always_comb begin
    state_d = state_q;
    e_d     = e_q;
    b_d     = b_q;
    len_d   = len_q;
    rem_d   = rem_q;
    low_d   = low_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    prod    = PW'(e_q) * PW'(b_q);
    trial   = {rem_q, low_q[7]};
    ge      = trial >= {1'b0, len_q};
    unique case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          e_d     = elapsed_i;
          b_d     = bright_i;
          len_d   = len_i;
          state_d = DV_MUL;
        end
      end
      DV_MUL: begin
        // Quotient stays below 256, so the top part is already below len.
        rem_d   = prod[PW-1:8];
        low_d   = prod[7:0];
        quot_d  = '0;
        cnt_d   = '0;
        state_d = DV_STEP;
      end
      DV_STEP: begin
        rem_d  = ge ? TIME_BITS'(trial - {1'b0, len_q}) : trial[TIME_BITS-1:0];
        quot_d = {quot_q[6:0], ge};
        low_d  = {low_q[6:0], 1'b0};
        cnt_d  = cnt_q + 3'd1;
        if (cnt_q == 3'(DIV_STEPS - 1)) begin
          done_d  = 1'b1;
          state_d = DV_IDLE;
        end
      end
      default: state_d = DV_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// File: rtl/ledc_state.sv
// Configuration registers and command state update of the LED drive.
`default_nettype none

module ledc_state
  import ledc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [31:0]             cfg_data_i,
  input  wire logic                    exec_i,
  input  wire led_req_t                req_i,
  output ledc_view_t                   view_o
);

  logic                 enabled_q, enabled_d, pwm_q, pwm_d;
  logic [31:0]          min_chg_q, min_chg_d, max_run_q, max_run_d;
  logic [TIME_BITS-1:0] now_q, now_d, last_q, last_d, rstart_q, rstart_d;
  logic [TIME_BITS-1:0] rlen_q, rlen_d, run_start_q, run_start_d;
  logic [31:0]          sum_q, sum_d, act_q, act_d;
  logic                 lit_q, lit_d, active_q, active_d, ok_q, ok_d;
  logic [7:0]           bright_q, bright_d;
  ramp_mode_e           mode_q, mode_d;

  logic [TIME_BITS-1:0] now_n, len_s;
  logic                 ramping, lock_ok, go_on, go_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      pwm_q       <= 1'b0;
      min_chg_q   <= MIN_CHANGE_RST;
      max_run_q   <= MAX_RUN_RST;
      now_q       <= '0;
      last_q      <= '0;
      rstart_q    <= '0;
      rlen_q      <= '0;
      run_start_q <= '0;
      sum_q       <= '0;
      act_q       <= '0;
      lit_q       <= 1'b0;
      active_q    <= 1'b0;
      ok_q        <= 1'b0;
      bright_q    <= BRIGHT_RST;
      mode_q      <= RAMP_NONE;
    end else begin
      enabled_q   <= enabled_d;
      pwm_q       <= pwm_d;
      min_chg_q   <= min_chg_d;
      max_run_q   <= max_run_d;
      now_q       <= now_d;
      last_q      <= last_d;
      rstart_q    <= rstart_d;
      rlen_q      <= rlen_d;
      run_start_q <= run_start_d;
      sum_q       <= sum_d;
      act_q       <= act_d;
      lit_q       <= lit_d;
      active_q    <= active_d;
      ok_q        <= ok_d;
      bright_q    <= bright_d;
      mode_q      <= mode_d;
    end
  end

  always_comb begin
    enabled_d   = enabled_q;
    pwm_d       = pwm_q;
    min_chg_d   = min_chg_q;
    max_run_d   = max_run_q;
    now_d       = now_q;
    last_d      = last_q;
    rstart_d    = rstart_q;
    rlen_d      = rlen_q;
    run_start_d = run_start_q;
    sum_d       = sum_q;
    act_d       = act_q;
    lit_d       = lit_q;
    active_d    = active_q;
    ok_d        = ok_q;
    bright_d    = bright_q;
    mode_d      = mode_q;

    now_n   = now_q + TIME_BITS'(1);
    len_s   = sat_len(req_i.ramp_ms);
    ramping = (mode_q != RAMP_NONE);
    lock_ok = CW'(TIME_BITS'(now_q - last_q)) >= CW'(min_chg_q);
    go_on   = (req_i.req_type == REQ_ON) || ((req_i.req_type == REQ_TOGGLE) && !lit_q);
    go_off  = (req_i.req_type == REQ_OFF) || ((req_i.req_type == REQ_TOGGLE) && lit_q);

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ENABLED:     enabled_d = cfg_data_i[0];
        CFG_PWM_CAPABLE: pwm_d     = cfg_data_i[0];
        CFG_MIN_CHANGE:  min_chg_d = cfg_data_i;
        CFG_MAX_RUN:     max_run_d = cfg_data_i;
        default: ;
      endcase
    end

    if (exec_i) begin
      ok_d = 1'b0;
      if (req_i.req_type == REQ_TICK) begin
        // Advance the clock, then end a ramp whose time is up.
        now_d = now_n;
        ok_d  = 1'b1;
        if (ramping && (TIME_BITS'(now_n - rstart_q) >= rlen_q)) begin
          if (mode_q == RAMP_OUT) begin
            if (active_q) begin
              sum_d    = sum_q + 32'(TIME_BITS'(now_n - run_start_q));
              active_d = 1'b0;
            end
            lit_d = 1'b0;
          end
          last_d = now_n;
          mode_d = RAMP_NONE;
        end
      end else if (enabled_q && !ramping) begin
        unique case (req_i.req_type)
          REQ_ON, REQ_OFF, REQ_TOGGLE: begin
            if (lock_ok) begin
              ok_d = 1'b1;
              if (go_on && !lit_q) begin
                lit_d  = 1'b1;
                last_d = now_q;
                act_d  = act_q + 32'd1;
                if (!active_q) begin
                  run_start_d = now_q;
                  active_d    = 1'b1;
                end
              end
              if (go_off && lit_q) begin
                if (active_q) begin
                  sum_d    = sum_q + 32'(TIME_BITS'(now_q - run_start_q));
                  active_d = 1'b0;
                end
                lit_d  = 1'b0;
                last_d = now_q;
              end
            end
          end
          REQ_BRIGHT: begin
            if (pwm_q) begin
              bright_d = req_i.level_value;
              ok_d     = 1'b1;
            end
          end
          REQ_PCT: begin
            if (pwm_q) begin
              bright_d = pct_to_level(req_i.level_value);
              ok_d     = 1'b1;
            end
          end
          REQ_FADEIN: begin
            if (pwm_q) begin
              lit_d = 1'b1;
              if (!active_q) begin
                run_start_d = now_q;
                active_d    = 1'b1;
                act_d       = act_q + 32'd1;
              end
              rstart_d = now_q;
              rlen_d   = len_s;
              // Zero length completes at once.
              if (len_s == '0) begin
                last_d = now_q;
                mode_d = RAMP_NONE;
              end else begin
                mode_d = RAMP_IN;
              end
              ok_d = 1'b1;
            end
          end
          REQ_FADEOUT: begin
            if (pwm_q && lit_q) begin
              rstart_d = now_q;
              rlen_d   = len_s;
              if (len_s == '0) begin
                if (active_q) begin
                  sum_d    = sum_q + 32'(TIME_BITS'(now_q - run_start_q));
                  active_d = 1'b0;
                end
                lit_d  = 1'b0;
                last_d = now_q;
                mode_d = RAMP_NONE;
              end else begin
                mode_d = RAMP_OUT;
              end
              ok_d = 1'b1;
            end
          end
          REQ_STATS: begin
            sum_d = '0;
            act_d = '0;
            ok_d  = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    view_o            = '0;
    view_o.ok         = ok_q;
    view_o.is_lit     = lit_q;
    view_o.run_active = active_q;
    view_o.ramp_mode  = mode_q;
    view_o.bright     = bright_q;
    view_o.pwm        = pwm_q;
    view_o.now        = now_q;
    view_o.ramp_start = rstart_q;
    view_o.ramp_len   = rlen_q;
    view_o.run_start  = run_start_q;
    view_o.run_sum    = sum_q;
    view_o.act        = act_q;
    view_o.max_run    = max_run_q;
  end

endmodule

`default_nettype wire

// File: rtl/led_drive_lockout_ramp_controller_unit.sv
// Top level of the LED drive controller: sequencer, response staging and output register.
//
// Requests enter on req_valid_i/req_ready_o carrying req_i (type, level, fade
// length); each request gives exactly one response on rsp_valid_o/rsp_ready_i.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; the port is always ready and should only be used while idle.
// A request is taken in the idle state, executed in the EXEC state, then the status
// is gathered in CALC. Without a running ramp the response goes on to DONE and is
// loaded into the output register from there once that register is free. While a
// ramp runs, the value elapsed*brightness/length comes from the shared ramp unit
// (a multiply, then 8 divide steps) while the sequencer waits in DIV; a fade-in
// drives that value, a fade-out brightness minus it. The next request is taken
// once the sequencer is back in idle, which it enters as the response is loaded.
// If the receiver stalls, the response holds in the output register; one more
// request can be worked meanwhile, its response waiting in the staging register.
// Reset clears the clock, statistics, lamp and ramp state, sets brightness to
// 255, lockout to 1000 ms and run limit to 43200000 ms; no response is pending.
`default_nettype none

module led_drive_lockout_ramp_controller_unit
  import ledc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    req_valid_i,
  output logic                         req_ready_o,
  input  wire led_req_t                req_i,
  output logic                         rsp_valid_o,
  input  wire logic                    rsp_ready_i,
  output led_rsp_t                     rsp_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [31:0]             cfg_data_i
);

  ledc_state_e          state_q, state_d;
  led_req_t             req_q, req_d;
  led_rsp_t             stage_q, stage_d, out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  ledc_view_t           view;
  logic                 div_start, div_done;
  logic [7:0]           div_quot, static_level;
  logic [TIME_BITS-1:0] cur, ramp_elapsed;
  logic                 ramping;

  ledc_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .exec_i      (state_q == ST_EXEC),
    .req_i       (req_q),
    .view_o      (view)
  );

  ledc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .elapsed_i (ramp_elapsed),
    .bright_i  (view.bright),
    .len_i     (view.ramp_len),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    stage_q <= stage_d;
    out_q   <= out_d;
  end

  // Status derived from the state after the request.
  always_comb begin
    ramping      = (view.ramp_mode != RAMP_NONE);
    ramp_elapsed = view.now - view.ramp_start;
    cur          = view.run_active ? TIME_BITS'(view.now - view.run_start) : '0;
    if (!view.is_lit) begin
      static_level = 8'd0;
    end else if (view.pwm) begin
      static_level = view.bright;
    end else begin
      static_level = 8'd1;
    end
  end

  assign div_start = (state_q == ST_CALC) && ramping;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    stage_d     = stage_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    // Drop the shown response once the receiver takes it.
    if (out_valid_q && rsp_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_CALC;
      ST_CALC: begin
        stage_d.accepted     = view.ok;
        stage_d.drive_level  = static_level;
        stage_d.lamp_on      = view.is_lit;
        stage_d.ramping      = ramping;
        stage_d.activations  = view.act;
        stage_d.run_total_ms = view.run_sum + 32'(cur);
        stage_d.over_limit   = view.run_active && (view.max_run != '0) &&
                               (CW'(cur) > CW'(view.max_run));
        state_d = ramping ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        // Hold until the ramp unit finishes; take its value, or brightness minus it.
        if (div_done) begin
          stage_d.drive_level = (view.ramp_mode == RAMP_IN) ? div_quot
                                                             : view.bright - div_quot;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          out_d       = stage_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

// File: rtl/ledc_checker.sv
// Port-level checks of the LED drive controller and their bind.
`default_nettype none

module ledc_checker
  import ledc_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    req_valid_i,
  input wire logic                    req_ready_o,
  input wire logic                    rsp_valid_o,
  input wire logic                    rsp_ready_i,
  input wire led_rsp_t                rsp_o
);

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  // A taken request keeps the block busy in the next cycle.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request taken while previous one still in work");

  // A ramp only runs on a lit strip.
  a_ramp_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.ramping |-> rsp_o.lamp_on)
    else $error("ramp reported on a dark strip");

  // A dark strip drives nothing and has no run over the limit.
  a_dark_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.lamp_on |-> (rsp_o.drive_level == 8'd0) && !rsp_o.over_limit)
    else $error("dark strip shows drive or run");

endmodule

bind led_drive_lockout_ramp_controller_unit ledc_checker u_ledc_checker (.*);

`default_nettype wire

// File: test/led_drive_lockout_ramp_controller_checker.sv
// Status predictor and response checker for the LED drive controller.
module led_drive_lockout_ramp_controller_checker
  import ledc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  input  logic                    req_ready_i,
  input  led_req_t                req_i,
  input  logic                    rsp_valid_i,
  input  logic                    rsp_ready_i,
  input  led_rsp_t                rsp_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  output int unsigned             fail_count_o,
  output int unsigned             open_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies.
  logic        en_q;
  logic        pwm_q;
  logic [31:0] min_gap_ms;
  logic [31:0] run_cap_ms;

  // Lamp, statistics and fade state.
  logic [31:0] clock_ms;
  logic [31:0] last_switch_ms;
  logic [31:0] run_begin_ms;
  logic [31:0] run_accum_ms;
  logic [31:0] activation_cnt;
  logic [31:0] fade_begin_ms;
  logic [31:0] fade_len_ms;
  logic        lit;
  logic        in_run;
  logic [7:0]  level;
  ramp_mode_e  fade;

  led_rsp_t    status_due_q[$];

  initial fail_count_o = 0;
  initial open_count_o = 0;

  function automatic void clear_state();
    en_q           = 1'b0;
    pwm_q          = 1'b0;
    min_gap_ms     = MIN_CHANGE_RST;
    run_cap_ms     = MAX_RUN_RST;
    clock_ms       = '0;
    last_switch_ms = '0;
    run_begin_ms   = '0;
    run_accum_ms   = '0;
    activation_cnt = '0;
    fade_begin_ms  = '0;
    fade_len_ms    = '0;
    lit            = 1'b0;
    in_run         = 1'b0;
    level          = BRIGHT_RST;
    fade           = RAMP_NONE;
  endfunction

  // The clock is exactly 32 bits wide, so plain subtraction wraps correctly.
  function automatic logic [31:0] age(input logic [31:0] t);
    return clock_ms - t;
  endfunction

  function automatic void open_run();
    if (!in_run) begin
      run_begin_ms   = clock_ms;
      in_run         = 1'b1;
      activation_cnt = activation_cnt + 32'd1;
    end
  endfunction

  function automatic void close_run();
    if (in_run) begin
      run_accum_ms = run_accum_ms + age(run_begin_ms);
      in_run       = 1'b0;
    end
  endfunction

  function automatic bit lockout_clear();
    return age(last_switch_ms) >= min_gap_ms;
  endfunction

  function automatic bit switch_on();
    if (!lockout_clear()) return 1'b0;
    if (!lit) begin
      lit            = 1'b1;
      last_switch_ms = clock_ms;
      activation_cnt = activation_cnt + 32'd1;
      if (!in_run) begin
        run_begin_ms = clock_ms;
        in_run       = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit switch_off();
    if (!lockout_clear()) return 1'b0;
    if (lit) begin
      close_run();
      lit            = 1'b0;
      last_switch_ms = clock_ms;
    end
    return 1'b1;
  endfunction

  // End the fade once its length has elapsed.
  function automatic void settle_fade();
    if (fade != RAMP_IN && fade != RAMP_OUT) begin
      fade = RAMP_NONE;
      return;
    end
    if (age(fade_begin_ms) < fade_len_ms) return;
    if (fade == RAMP_OUT) begin
      close_run();
      lit = 1'b0;
    end
    last_switch_ms = clock_ms;
    fade           = RAMP_NONE;
  endfunction

  function automatic logic [7:0] drive_now();
    logic [63:0] part;
    if (fade == RAMP_IN || fade == RAMP_OUT) begin
      part = 64'd0;
      if (fade_len_ms != 32'd0)
        part = (64'(age(fade_begin_ms)) * 64'(level)) / 64'(fade_len_ms);
      if (part > 64'(level)) part = 64'(level);
      return (fade == RAMP_IN) ? part[7:0] : level - part[7:0];
    end
    if (!lit) return 8'd0;
    return pwm_q ? level : 8'd1;
  endfunction

  function automatic led_rsp_t next_status(input led_req_t r);
    led_rsp_t    s;
    logic [31:0] cur;
    int unsigned scaled;
    bit          ok;
    bit          busy;
    ok   = 1'b0;
    busy = (fade != RAMP_NONE);
    if (r.req_type == REQ_TICK) begin
      clock_ms = clock_ms + 32'd1;
      if (busy) settle_fade();
      ok = 1'b1;
    end else if (en_q && !busy) begin
      case (r.req_type)
        REQ_ON:     ok = switch_on();
        REQ_OFF:    ok = switch_off();
        REQ_TOGGLE: ok = lit ? switch_off() : switch_on();
        REQ_BRIGHT: if (pwm_q) begin
          level = r.level_value;
          ok    = 1'b1;
        end
        REQ_PCT: if (pwm_q) begin
          scaled = r.level_value;
          scaled = scaled * 255 / 100;
          level  = (scaled > 255) ? 8'hFF : 8'(scaled);
          ok     = 1'b1;
        end
        REQ_FADEIN: if (pwm_q) begin
          lit = 1'b1;
          open_run();
          fade          = RAMP_IN;
          fade_begin_ms = clock_ms;
          fade_len_ms   = r.ramp_ms;
          settle_fade();
          ok = 1'b1;
        end
        REQ_FADEOUT: if (pwm_q && lit) begin
          fade          = RAMP_OUT;
          fade_begin_ms = clock_ms;
          fade_len_ms   = r.ramp_ms;
          settle_fade();
          ok = 1'b1;
        end
        REQ_STATS: begin
          run_accum_ms   = '0;
          activation_cnt = '0;
          ok             = 1'b1;
        end
        default: ;
      endcase
    end
    cur            = in_run ? age(run_begin_ms) : 32'd0;
    s.accepted     = ok;
    s.drive_level  = drive_now();
    s.lamp_on      = lit;
    s.ramping      = (fade != RAMP_NONE);
    s.activations  = activation_cnt;
    s.run_total_ms = run_accum_ms + cur;
    s.over_limit   = in_run && (run_cap_ms != 32'd0) && (cur > run_cap_ms);
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_status(input led_rsp_t got, input led_rsp_t want);
    if (got.accepted !== want.accepted)
      report_mismatch($sformatf("accepted: expected %0d got %0d", want.accepted, got.accepted));
    if (got.drive_level !== want.drive_level)
      report_mismatch($sformatf("drive_level: expected %0d got %0d",
                                want.drive_level, got.drive_level));
    if (got.lamp_on !== want.lamp_on)
      report_mismatch($sformatf("lamp_on: expected %0d got %0d", want.lamp_on, got.lamp_on));
    if (got.ramping !== want.ramping)
      report_mismatch($sformatf("ramping: expected %0d got %0d", want.ramping, got.ramping));
    if (got.activations !== want.activations)
      report_mismatch($sformatf("activations: expected %0d got %0d",
                                want.activations, got.activations));
    if (got.run_total_ms !== want.run_total_ms)
      report_mismatch($sformatf("run_total_ms: expected %0d got %0d",
                                want.run_total_ms, got.run_total_ms));
    if (got.over_limit !== want.over_limit)
      report_mismatch($sformatf("over_limit: expected %0d got %0d",
                                want.over_limit, got.over_limit));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      status_due_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ENABLED:     en_q       = cfg_data_i[0];
          CFG_PWM_CAPABLE: pwm_q      = cfg_data_i[0];
          CFG_MIN_CHANGE:  min_gap_ms = cfg_data_i;
          CFG_MAX_RUN:     run_cap_ms = cfg_data_i;
          default: ;
        endcase
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (status_due_q.size() == 0) report_mismatch("status response with none expected");
        else check_status(rsp_i, status_due_q.pop_front());
      end
      if (req_valid_i && req_ready_i) status_due_q.push_back(next_status(req_i));
    end
    open_count_o = status_due_q.size();
  end

endmodule

// File: test/led_drive_lockout_ramp_controller_unit_tb.sv
// Top of the LED drive controller testbench: clock, reset, request stimulus and verdict.
module led_drive_lockout_ramp_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ledc_pkg::*;

  localparam int unsigned IDLE_PCT        = 18;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned PHASE_ITEMS     = 160;
  localparam int unsigned CYCLE_LIMIT     = 600000;

  // Request types with no meaning, and a register index that selects nothing.
  localparam logic [3:0]              REQ_UNKNOWN_LO = 4'd9;
  localparam logic [3:0]              REQ_UNKNOWN_HI = 4'd15;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE      = 8'hFF;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    req_valid = 1'b0;
  logic                    req_ready;
  led_req_t                req_data = '0;
  logic                    rsp_valid;
  logic                    rsp_ready = 1'b0;
  led_rsp_t                rsp_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0]             cfg_data = '0;
  int unsigned             fail_count;
  int unsigned             open_count;
  int unsigned             cycle_count = 0;

  // Stimulus-side controls for the receiver process.
  bit quiet_mode    = 1'b0;
  bit hold_off_go   = 1'b0;
  bit hold_off_done = 1'b0;

  led_drive_lockout_ramp_controller_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req_data),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  led_drive_lockout_ramp_controller_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (req_valid),
    .req_ready_i  (req_ready),
    .req_i        (req_data),
    .rsp_valid_i  (rsp_valid),
    .rsp_ready_i  (rsp_ready),
    .rsp_i        (rsp_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .open_count_o (open_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Kill the run if it hangs; the bound is many times the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Status receiver: stall at random, hold off for a long stretch once on
  // request so the block backs up into its request input.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_go && !hold_off_done) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_done = 1'b1;
      end else begin
        rsp_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one request; entered and left at a falling edge. Drop valid for
  // random gaps first, then hold the request until the block takes it.
  task automatic push_request(input led_req_t r);
    while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic issue(input logic [3:0] kind, input logic [7:0] lvl, input logic [31:0] len);
    led_req_t r;
    r.req_type    = kind;
    r.level_value = lvl;
    r.ramp_ms     = len;
    push_request(r);
  endtask

  task automatic issue_ticks(input int unsigned n);
    repeat (n) issue(REQ_TICK, 8'($urandom()), $urandom());
  endtask

  // Mostly ticks so the millisecond clock moves, with commands mixed in.
  // Fades get short lengths so ramps finish and commands get through again;
  // the length field of other requests is ignored and takes any value.
  function automatic led_req_t random_request();
    led_req_t    r;
    int unsigned pick;
    pick          = $urandom_range(99);
    r.level_value = 8'($urandom_range(255));
    r.ramp_ms     = $urandom();
    if (pick < 45)      r.req_type = REQ_TICK;
    else if (pick < 52) r.req_type = REQ_ON;
    else if (pick < 59) r.req_type = REQ_OFF;
    else if (pick < 66) r.req_type = REQ_TOGGLE;
    else if (pick < 71) r.req_type = REQ_BRIGHT;
    else if (pick < 76) r.req_type = REQ_PCT;
    else if (pick < 83) r.req_type = REQ_FADEIN;
    else if (pick < 89) r.req_type = REQ_FADEOUT;
    else if (pick < 94) r.req_type = REQ_STATS;
    else r.req_type = 4'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO));
    if (r.req_type == REQ_FADEIN || r.req_type == REQ_FADEOUT)
      r.ramp_ms = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(12));
    return r;
  endfunction

  task automatic run_phase(input int unsigned n);
    repeat (n) push_request(random_request());
  endtask

  // Drop valid and wait until every status has come back, then give the
  // sequencer time to return to idle before touching registers.
  task automatic drain();
    req_valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Hold valid across back-to-back writes; lower it only after the last.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all four registers; the one-bit ones carry junk in the upper bits.
  task automatic configure(input bit en, input bit pwm, input logic [31:0] min_gap,
                           input logic [31:0] run_cap, input bit with_spare);
    write_reg(CFG_ENABLED, {31'($urandom()), en});
    write_reg(CFG_PWM_CAPABLE, {31'($urandom()), pwm});
    write_reg(CFG_MIN_CHANGE, min_gap);
    write_reg(CFG_MAX_RUN, run_cap);
    if (with_spare) write_reg(CFG_SPARE, $urandom());
    cfg_valid <= 1'b0;
  endtask

  // Close a random phase with a short fade so the next register setting
  // lands while a ramp may still be running.
  task automatic end_phase();
    issue(REQ_FADEIN, 8'($urandom()), 32'($urandom_range(10, 4)));
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Registers at reset: driver disabled, so every command but the tick is refused.
    issue(REQ_TICK, 8'h00, 32'h0000_0000);
    issue(REQ_ON, 8'hFF, 32'hFFFF_FFFF);
    issue(REQ_FADEIN, 8'h00, 32'd3);
    issue(REQ_UNKNOWN_LO, 8'h00, 32'd0);
    drain();

    // Lockout: the clock stays short of five milliseconds, so the on, the on
    // after three ticks and the off that follows are all refused.
    configure(1'b1, 1'b1, 32'd5, 32'd0, 1'b0);
    issue(REQ_ON, 8'd0, 32'd0);
    issue_ticks(3);
    issue(REQ_ON, 8'd0, 32'd0);
    issue(REQ_OFF, 8'd0, 32'd0);
    drain();

    // No lockout, two-millisecond run limit: brightness extremes, percent
    // saturation, a redundant off, toggles, zero-length fades, a fade
    // with a command refused mid-ramp, and a statistics clear.
    configure(1'b1, 1'b1, 32'd0, 32'd2, 1'b0);
    issue(REQ_BRIGHT, 8'd0, 32'd0);
    issue(REQ_BRIGHT, 8'd255, 32'd0);
    issue(REQ_PCT, 8'd0, 32'd0);
    issue(REQ_PCT, 8'd100, 32'd0);
    issue(REQ_PCT, 8'd255, 32'd0);
    issue(REQ_PCT, 8'd39, 32'd0);
    issue_ticks(3);
    issue(REQ_ON, 8'd0, 32'd0);
    issue(REQ_OFF, 8'd0, 32'd0);
    issue(REQ_OFF, 8'd0, 32'd0);
    issue(REQ_TOGGLE, 8'd0, 32'd0);
    issue(REQ_TOGGLE, 8'd0, 32'd0);
    issue(REQ_FADEIN, 8'd0, 32'd0);
    issue(REQ_FADEOUT, 8'd0, 32'd0);
    issue(REQ_FADEIN, 8'd0, 32'd4);
    issue(REQ_ON, 8'd0, 32'd0);
    issue_ticks(4);
    issue(REQ_FADEOUT, 8'd0, 32'd3);
    issue_ticks(3);
    issue(REQ_STATS, 8'd0, 32'd0);
    issue(REQ_UNKNOWN_HI, 8'hFF, 32'hFFFF_FFFF);
    drain();

    // Random phases over several register settings. Start with a stretch
    // where neither side idles.
    configure(1'b1, 1'b1, 32'd0, 32'd0, 1'b0);
    quiet_mode = 1'b1;
    run_phase(PHASE_ITEMS / 2);
    quiet_mode = 1'b0;
    run_phase(PHASE_ITEMS / 2);
    end_phase();

    // Short lockout and limit; trigger the long receiver hold-off.
    configure(1'b1, 1'b1, 32'd3, 32'd7, 1'b0);
    hold_off_go = 1'b1;
    run_phase(PHASE_ITEMS);
    end_phase();

    // Digital pin mode: brightness and fades refused, drive level 0 or 1.
    configure(1'b1, 1'b0, 32'd1, 32'd20, 1'b0);
    run_phase(PHASE_ITEMS);
    end_phase();

    // Disabled: only ticks get through.
    configure(1'b0, 1'b1, 32'd0, 32'd1, 1'b0);
    run_phase(PHASE_ITEMS);
    end_phase();

    // Largest lockout and limit: on and off stay locked, fades still work.
    configure(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    run_phase(PHASE_ITEMS);
    end_phase();

    // Final setting, with a write to an index that selects nothing.
    configure(1'b1, 1'b1, 32'd2, 32'd3, 1'b1);
    run_phase(PHASE_ITEMS);

    // Let any ramp finish, then start one of the longest length; it never
    // ends, so keep it for the close of the run.
    issue_ticks(15);
    issue(REQ_FADEIN, 8'd0, 32'hFFFF_FFFF);
    issue_ticks(6);
    issue(REQ_ON, 8'd0, 32'd0);
    issue(REQ_FADEOUT, 8'd0, 32'hFFFF_FFFF);
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ledc_pkg.sv
rtl/ledc_div.sv
rtl/ledc_state.sv
rtl/led_drive_lockout_ramp_controller_unit.sv
rtl/ledc_checker.sv
test/led_drive_lockout_ramp_controller_checker.sv
test/led_drive_lockout_ramp_controller_unit_tb.sv
